@@ design/nfb_pkg.sv @@
package nfb_pkg;

    // Field widths of the command and result items.
    localparam int OP_W     = 3;
    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int COLOR_W  = 4;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 10;

    // Configuration register widths.
    localparam int PITCH_W = 10;
    localparam int XRES_W  = 11;
    localparam int YRES_W  = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RES      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RES      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_MODE   = 4'd3;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 10'd320;
    localparam logic [XRES_W-1:0]  XRES_RESET  = 11'd640;
    localparam logic [YRES_W-1:0]  YRES_RESET  = 10'd480;

    // Byte address before the range check: a 9-bit row times a 10-bit pitch
    // plus a 9-bit byte column.
    localparam int ADDR_FULL_W = Y_W + PITCH_W + 1;

    localparam logic [7:0] NIB_LO_MASK = 8'h0f;
    localparam logic [7:0] NIB_HI_MASK = 8'hf0;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW  = 3'd0,
        OP_READ  = 3'd1,
        OP_HLINE = 3'd2,
        OP_VLINE = 3'd3,
        OP_COPY  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ADDR,
        ST_READ,
        ST_MODIFY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_FULL_W-1:0] addr;
        logic                   in_range;
    } addr_res_t;

endpackage

@@ design/nfb_if.sv @@
interface nfb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [nfb_pkg::OP_W-1:0]      op;
    logic [nfb_pkg::X_W-1:0]       x;
    logic [nfb_pkg::Y_W-1:0]       y;
    logic [nfb_pkg::X_W-1:0]       x_end;
    logic [nfb_pkg::Y_W-1:0]       y_end;
    logic [nfb_pkg::COLOR_W-1:0]   color;
    logic [nfb_pkg::X_W-1:0]       src_x;
    logic [nfb_pkg::Y_W-1:0]       src_y;
    logic [nfb_pkg::WIDTH_W-1:0]   width;
    logic [nfb_pkg::HEIGHT_W-1:0]  height;

    modport source (output valid, op, x, y, x_end, y_end, color, src_x, src_y, width, height,
                    input ready);
    modport sink (input valid, op, x, y, x_end, y_end, color, src_x, src_y, width, height,
                  output ready);
endinterface

interface nfb_res_if;
    logic                          valid;
    logic                          ready;
    logic [nfb_pkg::COLOR_W-1:0]   pixel;
    logic                          fault;

    modport source (output valid, pixel, fault, input ready);
    modport sink (input valid, pixel, fault, output ready);
endinterface

interface nfb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nfb_pkg::CFG_IDX_W-1:0]  index;
    logic [nfb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/nibble_framebuffer_draw_engine_core.sv @@
// Channel  Dir  Signals                                              Transfer when
// -------  ---  ---------------------------------------------------  ---------------------
// cmd      in   op x y x_end y_end color src_x src_y width height    cmd.valid & cmd.ready
// res      out  pixel fault                                          res.valid & res.ready
// cfg      in   index data (0 pitch, 1 x_res, 2 y_res, 3 xor_mode)   cfg.valid & cfg.ready
//
// After reset the frame store is swept to zero, one byte per cycle, over all FRAME_BYTES
// addresses; cmd.ready stays low during the sweep while cfg transfers are taken as ever.
// A command is latched in IDLE and checked in CHECK; each byte access then passes ADDR,
// READ and MODIFY through the shared address multiplier and the store's one write and
// one read port: a draw or read is one access, a line one per pixel, a copy two per pixel.
// One command is in flight at a time; the result sits in an output register, so the next
// command can be accepted while the previous result waits on res.ready.
module nibble_framebuffer_draw_engine_core #(
    parameter int FRAME_BYTES = 262144,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 512,
    parameter int MAX_PITCH   = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    nfb_cmd_if.sink    cmd,
    nfb_res_if.source  res,
    nfb_cfg_if.sink    cfg
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);

    // Configuration registers.
    logic [nfb_pkg::PITCH_W-1:0] pitch_reg;
    logic [nfb_pkg::XRES_W-1:0]  x_res_reg;
    logic [nfb_pkg::YRES_W-1:0]  y_res_reg;
    logic                        xor_mode_reg;

    // Limited copies of the resolution and pitch used by every check and address.
    logic [nfb_pkg::PITCH_W-1:0] pitch_lim;
    logic [nfb_pkg::XRES_W-1:0]  xr;
    logic [nfb_pkg::YRES_W-1:0]  yr;

    // Sequencer control.
    nfb_pkg::state_t     state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                src_phase_reg, src_phase_next;
    logic                out_valid_reg, out_valid_next;

    // Latched command.
    logic [nfb_pkg::OP_W-1:0]      op_reg, op_next;
    logic [nfb_pkg::X_W-1:0]       x_reg, x_next;
    logic [nfb_pkg::Y_W-1:0]       y_reg, y_next;
    logic [nfb_pkg::X_W-1:0]       x_end_reg, x_end_next;
    logic [nfb_pkg::Y_W-1:0]       y_end_reg, y_end_next;
    logic [nfb_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic [nfb_pkg::X_W-1:0]       src_x_reg, src_x_next;
    logic [nfb_pkg::Y_W-1:0]       src_y_reg, src_y_next;
    logic [nfb_pkg::WIDTH_W-1:0]   width_reg, width_next;
    logic [nfb_pkg::HEIGHT_W-1:0]  height_reg, height_next;

    // Walk position: destination column and row, copy source column and row,
    // and how many columns and rows are still to go in a copy.
    logic [nfb_pkg::X_W-1:0]       col_reg, col_next;
    logic [nfb_pkg::Y_W-1:0]       row_reg, row_next;
    logic [nfb_pkg::X_W-1:0]       scol_reg, scol_next;
    logic [nfb_pkg::Y_W-1:0]       srow_reg, srow_next;
    logic [nfb_pkg::WIDTH_W-1:0]   col_left_reg, col_left_next;
    logic [nfb_pkg::HEIGHT_W-1:0]  row_left_reg, row_left_next;

    // Working result and the output register.
    logic [nfb_pkg::COLOR_W-1:0]   src_nib_reg, src_nib_next;
    logic [nfb_pkg::COLOR_W-1:0]   res_pix_reg, res_pix_next;
    logic                          res_fault_reg, res_fault_next;
    logic [nfb_pkg::COLOR_W-1:0]   out_pix_reg, out_pix_next;
    logic                          out_fault_reg, out_fault_next;

    // Shared address unit.
    logic                          addr_load;
    logic [nfb_pkg::X_W-1:0]       addr_px;
    logic [nfb_pkg::Y_W-1:0]       addr_py;
    nfb_pkg::addr_res_t            addr_res;

    // Frame store.
    logic [7:0]                    mem [FRAME_BYTES];
    logic [7:0]                    rd_data_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [7:0]                    mem_wdata;
    logic [ADDR_W-1:0]             rd_idx;

    // Checks and byte merge.
    logic                          x_ok, y_ok, cmd_ok;
    logic [nfb_pkg::WIDTH_W:0]     dst_x_span, src_x_span;
    logic [nfb_pkg::HEIGHT_W:0]    dst_y_span, src_y_span;
    logic                          is_copy;
    logic [nfb_pkg::COLOR_W-1:0]   put_nib;
    logic [7:0]                    put_byte;
    logic [7:0]                    keep_mask;
    logic [7:0]                    merged;
    logic [nfb_pkg::COLOR_W-1:0]   cur_nib;
    logic                          cur_lsb;

    // Registers above the hardware limits are clamped to them.
    assign pitch_lim = (32'(pitch_reg) > 32'(MAX_PITCH))  ? nfb_pkg::PITCH_W'(MAX_PITCH) : pitch_reg;
    assign xr        = (32'(x_res_reg) > 32'(MAX_WIDTH))  ? nfb_pkg::XRES_W'(MAX_WIDTH)  : x_res_reg;
    assign yr        = (32'(y_res_reg) > 32'(MAX_HEIGHT)) ? nfb_pkg::YRES_W'(MAX_HEIGHT) : y_res_reg;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg    <= nfb_pkg::PITCH_RESET;
            x_res_reg    <= nfb_pkg::XRES_RESET;
            y_res_reg    <= nfb_pkg::YRES_RESET;
            xor_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                nfb_pkg::CFG_LINE_PITCH: pitch_reg    <= cfg.data[nfb_pkg::PITCH_W-1:0];
                nfb_pkg::CFG_X_RES:      x_res_reg    <= cfg.data[nfb_pkg::XRES_W-1:0];
                nfb_pkg::CFG_Y_RES:      y_res_reg    <= cfg.data[nfb_pkg::YRES_W-1:0];
                nfb_pkg::CFG_XOR_MODE:   xor_mode_reg <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    // Coordinate checks on the latched command. The spans are one bit wider than
    // their operands, so a rectangle running past the right or bottom edge is seen.
    assign is_copy    = op_reg == nfb_pkg::OP_COPY;
    assign x_ok       = {1'b0, x_reg} < xr;
    assign y_ok       = {1'b0, y_reg} < yr;
    assign dst_x_span = {2'b00, x_reg} + {1'b0, width_reg};
    assign src_x_span = {2'b00, src_x_reg} + {1'b0, width_reg};
    assign dst_y_span = {2'b00, y_reg} + {1'b0, height_reg};
    assign src_y_span = {2'b00, src_y_reg} + {1'b0, height_reg};

    always_comb
    begin
        case (op_reg)
            nfb_pkg::OP_DRAW,
            nfb_pkg::OP_READ:  cmd_ok = x_ok && y_ok;
            nfb_pkg::OP_HLINE: cmd_ok = x_ok && y_ok && ({1'b0, x_end_reg} < xr)
                                        && (x_end_reg >= x_reg);
            nfb_pkg::OP_VLINE: cmd_ok = x_ok && y_ok && ({1'b0, y_end_reg} < yr)
                                        && (y_end_reg >= y_reg);
            nfb_pkg::OP_COPY:  cmd_ok = (width_reg != '0) && (height_reg != '0)
                                        && x_ok && y_ok
                                        && ({1'b0, src_x_reg} < xr) && ({1'b0, src_y_reg} < yr)
                                        && (dst_x_span <= {1'b0, xr})
                                        && (src_x_span <= {1'b0, xr})
                                        && (dst_y_span <= {1'b0, yr})
                                        && (src_y_span <= {1'b0, yr});
            default:           cmd_ok = 1'b0;
        endcase
    end

    // The address unit looks at the copy source during the fetch half of a copy
    // step and at the destination otherwise.
    assign addr_px = (is_copy && src_phase_reg) ? scol_reg : col_reg;
    assign addr_py = (is_copy && src_phase_reg) ? srow_reg : row_reg;

    nfb_addr_unit #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_addr (
        .clk   (clk),
        .load  (addr_load),
        .px    (addr_px),
        .py    (addr_py),
        .pitch (pitch_lim),
        .res   (addr_res)
    );

    // Nibble taken from the byte just read; an even column sits in the high nibble.
    // Bytes beyond the store read as zero.
    assign cur_lsb = (is_copy && src_phase_reg) ? scol_reg[0] : col_reg[0];
    assign cur_nib = !addr_res.in_range ? '0 : (cur_lsb ? rd_data_reg[3:0] : rd_data_reg[7:4]);

    // Byte merge for the destination: replace keeps the other nibble, XOR mode
    // flips bits in place. A copy always replaces.
    assign put_nib   = is_copy ? src_nib_reg : color_reg;
    assign put_byte  = col_reg[0] ? {4'h0, put_nib} : {put_nib, 4'h0};
    assign keep_mask = col_reg[0] ? nfb_pkg::NIB_HI_MASK : nfb_pkg::NIB_LO_MASK;
    assign merged    = (xor_mode_reg && !is_copy) ? (rd_data_reg ^ put_byte)
                                                  : ((rd_data_reg & keep_mask) | put_byte);

    assign rd_idx = ADDR_W'(addr_res.addr);

    assign cmd.ready = state_reg == nfb_pkg::ST_IDLE;
    assign res.valid = out_valid_reg;
    assign res.pixel = out_pix_reg;
    assign res.fault = out_fault_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        src_phase_next = src_phase_reg;
        out_valid_next = out_valid_reg && !res.ready;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        color_next     = color_reg;
        src_x_next     = src_x_reg;
        src_y_next     = src_y_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        scol_next      = scol_reg;
        srow_next      = srow_reg;
        col_left_next  = col_left_reg;
        row_left_next  = row_left_reg;
        src_nib_next   = src_nib_reg;
        res_pix_next   = res_pix_reg;
        res_fault_next = res_fault_reg;
        out_pix_next   = out_pix_reg;
        out_fault_next = out_fault_reg;
        addr_load      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = rd_idx;
        mem_wdata      = merged;

        case (state_reg)
            nfb_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == ADDR_W'(FRAME_BYTES - 1))
                    state_next = nfb_pkg::ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end

            nfb_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = cmd.op;
                    x_next      = cmd.x;
                    y_next      = cmd.y;
                    x_end_next  = cmd.x_end;
                    y_end_next  = cmd.y_end;
                    color_next  = cmd.color;
                    src_x_next  = cmd.src_x;
                    src_y_next  = cmd.src_y;
                    width_next  = cmd.width;
                    height_next = cmd.height;
                    state_next  = nfb_pkg::ST_CHECK;
                end
            end

            nfb_pkg::ST_CHECK:
            begin
                res_fault_next = !cmd_ok;
                res_pix_next   = '0;
                col_next       = x_reg;
                row_next       = y_reg;
                scol_next      = src_x_reg;
                srow_next      = src_y_reg;
                col_left_next  = width_reg - 1'b1;
                row_left_next  = height_reg - 1'b1;
                src_phase_next = is_copy;
                state_next     = cmd_ok ? nfb_pkg::ST_ADDR : nfb_pkg::ST_RESP;
            end

            nfb_pkg::ST_ADDR:
            begin
                addr_load  = 1'b1;
                state_next = nfb_pkg::ST_READ;
            end

            // The store's registered read data arrives at the end of this cycle.
            nfb_pkg::ST_READ:
            begin
                state_next = nfb_pkg::ST_MODIFY;
            end

            nfb_pkg::ST_MODIFY:
            begin
                state_next = nfb_pkg::ST_ADDR;
                case (op_reg)
                    nfb_pkg::OP_READ:
                    begin
                        res_pix_next = cur_nib;
                        state_next   = nfb_pkg::ST_RESP;
                    end

                    nfb_pkg::OP_DRAW:
                    begin
                        mem_we     = addr_res.in_range;
                        state_next = nfb_pkg::ST_RESP;
                    end

                    nfb_pkg::OP_HLINE:
                    begin
                        mem_we = addr_res.in_range;
                        if (col_reg == x_end_reg)
                            state_next = nfb_pkg::ST_RESP;
                        else
                            col_next = col_reg + 1'b1;
                    end

                    nfb_pkg::OP_VLINE:
                    begin
                        mem_we = addr_res.in_range;
                        if (row_reg == y_end_reg)
                            state_next = nfb_pkg::ST_RESP;
                        else
                            row_next = row_reg + 1'b1;
                    end

                    nfb_pkg::OP_COPY:
                    begin
                        if (src_phase_reg)
                        begin
                            // Fetch half: hold the source pixel for the write half.
                            src_nib_next   = cur_nib;
                            src_phase_next = 1'b0;
                        end
                        else
                        begin
                            mem_we         = addr_res.in_range;
                            src_phase_next = 1'b1;
                            if (col_left_reg == '0)
                            begin
                                if (row_left_reg == '0)
                                begin
                                    state_next = nfb_pkg::ST_RESP;
                                end
                                else
                                begin
                                    row_left_next = row_left_reg - 1'b1;
                                    row_next      = row_reg + 1'b1;
                                    srow_next     = srow_reg + 1'b1;
                                    col_next      = x_reg;
                                    scol_next     = src_x_reg;
                                    col_left_next = width_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                col_left_next = col_left_reg - 1'b1;
                                col_next      = col_reg + 1'b1;
                                scol_next     = scol_reg + 1'b1;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = nfb_pkg::ST_RESP;
                    end
                endcase
            end

            // The result moves to the output register once the previous one is gone.
            nfb_pkg::ST_RESP:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = res_pix_reg;
                    out_fault_next = res_fault_reg;
                    src_phase_next = 1'b0;
                    state_next     = nfb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfb_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            src_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            src_phase_reg <= src_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        x_end_reg     <= x_end_next;
        y_end_reg     <= y_end_next;
        color_reg     <= color_next;
        src_x_reg     <= src_x_next;
        src_y_reg     <= src_y_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        scol_reg      <= scol_next;
        srow_reg      <= srow_next;
        col_left_reg  <= col_left_next;
        row_left_reg  <= row_left_next;
        src_nib_reg   <= src_nib_next;
        res_pix_reg   <= res_pix_next;
        res_fault_reg <= res_fault_next;
        out_pix_reg   <= out_pix_next;
        out_fault_reg <= out_fault_next;
    end

    // Frame store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_idx];
    end

`ifndef SYNTHESIS
    // No result can appear while the store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nfb_pkg::ST_CLEAR |-> !res.valid)
        else $error("result presented during the clearing sweep");

    // An accepted command is always checked in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> state_reg == nfb_pkg::ST_CHECK)
        else $error("accepted command not checked");

    // A rejected command never carries pixel data.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.fault |-> res.pixel == '0)
        else $error("faulted result with nonzero pixel");

    // Stores happen only in the sweep or in the write step of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == nfb_pkg::ST_CLEAR
                   || (state_reg == nfb_pkg::ST_MODIFY && !res_fault_reg))
        else $error("frame store written outside a write step");

    // The fetch half only exists while a copy is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        src_phase_reg && state_reg == nfb_pkg::ST_MODIFY |-> is_copy)
        else $error("source fetch outside a copy");
`endif

endmodule

@@ design/nfb_addr_unit.sv @@
module nfb_addr_unit #(
    parameter int FRAME_BYTES = 262144
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [nfb_pkg::X_W-1:0]       px,
    input  logic [nfb_pkg::Y_W-1:0]       py,
    input  logic [nfb_pkg::PITCH_W-1:0]   pitch,
    output nfb_pkg::addr_res_t            res
);

    localparam int PROD_W = nfb_pkg::Y_W + nfb_pkg::PITCH_W;

    logic [PROD_W-1:0]               prod;
    logic [nfb_pkg::ADDR_FULL_W-1:0] sum;
    nfb_pkg::addr_res_t              res_reg;
    nfb_pkg::addr_res_t              res_next;

    // Row base times pitch plus the byte column; the even pixel shares its
    // byte with the odd one to its right.
    always_comb
    begin
        prod = {{nfb_pkg::PITCH_W{1'b0}}, py} * {{nfb_pkg::Y_W{1'b0}}, pitch};
        sum  = nfb_pkg::ADDR_FULL_W'(prod) + nfb_pkg::ADDR_FULL_W'(px[nfb_pkg::X_W-1:1]);
        res_next = res_reg;
        if (load)
        begin
            res_next.addr     = sum;
            res_next.in_range = 32'(sum) < 32'(FRAME_BYTES);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

@@ tb/tb_nibble_framebuffer_draw_engine_core.sv @@
module tb_nibble_framebuffer_draw_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nfb_pkg::*;

    // Register index that decodes to nothing, and the range of undefined opcodes.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 4'hf;
    localparam logic [OP_W-1:0]      OP_UNDEF_LO  = 3'd5;
    localparam logic [OP_W-1:0]      OP_UNDEF_HI  = 3'd7;

    // One command as it goes over the cmd channel.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [X_W-1:0]      x_end;
        logic [Y_W-1:0]      y_end;
        logic [COLOR_W-1:0]  color;
        logic [X_W-1:0]      src_x;
        logic [Y_W-1:0]      src_y;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cmd_item_t;

    // One result as it comes back over the res channel.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               fault;
    } draw_result_t;

    // The scoreboard keeps its own image of the frame store and of the registers.
    // Each accepted command is played against that image right away, and the result
    // it must give is queued; results from the block are matched in order.
    class draw_scoreboard;
        localparam int STORE_BYTES = 262144;
        localparam int LIM_WIDTH   = 1024;
        localparam int LIM_HEIGHT  = 512;
        localparam int LIM_PITCH   = 512;

        bit [7:0]          store_img [STORE_BYTES];
        bit [PITCH_W-1:0]  pitch_q;
        bit [XRES_W-1:0]   xres_q;
        bit [YRES_W-1:0]   yres_q;
        bit                xor_q;
        draw_result_t      expected_q [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       rejected;
        int unsigned       per_op [8];

        function new();
            pitch_q = PITCH_RESET;
            xres_q  = XRES_RESET;
            yres_q  = YRES_RESET;
            xor_q   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINE_PITCH: pitch_q = data[PITCH_W-1:0];
                CFG_X_RES:      xres_q  = data[XRES_W-1:0];
                CFG_Y_RES:      yres_q  = data[YRES_W-1:0];
                CFG_XOR_MODE:   xor_q   = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned m);
            return (v > m) ? m : v;
        endfunction

        function int unsigned eff_xres();
            return clamp(xres_q, LIM_WIDTH);
        endfunction

        function int unsigned eff_yres();
            return clamp(yres_q, LIM_HEIGHT);
        endfunction

        function int unsigned byte_at(int unsigned x, int unsigned y);
            return y * clamp(pitch_q, LIM_PITCH) + (x >> 1);
        endfunction

        // Even x lives in the high nibble.
        function bit [3:0] peek(int unsigned x, int unsigned y);
            int unsigned a;
            a = byte_at(x, y);
            if (a >= STORE_BYTES)
                return 4'h0;
            return x[0] ? store_img[a][3:0] : store_img[a][7:4];
        endfunction

        function void poke(int unsigned x, int unsigned y, bit [3:0] c, bit use_xor);
            int unsigned a;
            a = byte_at(x, y);
            if (a >= STORE_BYTES)
                return;
            if (x[0])
                store_img[a][3:0] = use_xor ? (store_img[a][3:0] ^ c) : c;
            else
                store_img[a][7:4] = use_xor ? (store_img[a][7:4] ^ c) : c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(cmd_item_t it);
            int unsigned  xr;
            int unsigned  yr;
            int unsigned  x;
            int unsigned  y;
            int unsigned  xe;
            int unsigned  ye;
            int unsigned  sx;
            int unsigned  sy;
            int unsigned  w;
            int unsigned  h;
            draw_result_t r;
            xr = eff_xres();
            yr = eff_yres();
            x  = it.x;
            y  = it.y;
            xe = it.x_end;
            ye = it.y_end;
            sx = it.src_x;
            sy = it.src_y;
            w  = it.width;
            h  = it.height;
            r.pixel = '0;
            r.fault = 1'b0;
            case (it.op)
                OP_DRAW:
                    if (x < xr && y < yr)
                        poke(x, y, it.color, xor_q);
                    else
                        r.fault = 1'b1;
                OP_READ:
                    if (x < xr && y < yr)
                        r.pixel = peek(x, y);
                    else
                        r.fault = 1'b1;
                OP_HLINE:
                    if (x < xr && xe < xr && xe >= x && y < yr) begin
                        for (int unsigned i = x; i <= xe; i++)
                            poke(i, y, it.color, xor_q);
                    end else begin
                        r.fault = 1'b1;
                    end
                OP_VLINE:
                    if (x < xr && y < yr && ye < yr && ye >= y) begin
                        for (int unsigned j = y; j <= ye; j++)
                            poke(x, j, it.color, xor_q);
                    end else begin
                        r.fault = 1'b1;
                    end
                OP_COPY:
                    // Row by row, left to right, each source pixel read just before
                    // its destination is written, so overlapping copies smear.
                    if (w > 0 && h > 0 && x < xr && y < yr && sx < xr && sy < yr &&
                        x + w <= xr && y + h <= yr && sx + w <= xr && sy + h <= yr) begin
                        for (int unsigned j = 0; j < h; j++)
                            for (int unsigned i = 0; i < w; i++)
                                poke(x + i, y + j, peek(sx + i, sy + j), 1'b0);
                    end else begin
                        r.fault = 1'b1;
                    end
                default:
                    r.fault = 1'b1;
            endcase
            per_op[it.op]++;
            if (r.fault)
                rejected++;
            expected_q.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 30)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [COLOR_W-1:0] pixel, logic fault);
            draw_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("result pixel=%0h fault=%0b with no command outstanding",
                                 pixel, fault));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (pixel !== e.pixel)
                report($sformatf("result %0d: pixel %0h, predicted %0h",
                                 checked, pixel, e.pixel));
            if (fault !== e.fault)
                report($sformatf("result %0d: fault %0b, predicted %0b",
                                 checked, fault, e.fault));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nfb_cmd_if cmd_ch ();
    nfb_res_if res_ch ();
    nfb_cfg_if cfg_ch ();

    nibble_framebuffer_draw_engine_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    draw_scoreboard sb = new();

    // When set, neither side inserts idle cycles.
    bit          no_idle;
    int unsigned settings_used;
    int unsigned results_seen;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cmd_item_t cmd_of(int unsigned op, int unsigned x, int unsigned y,
                                         int unsigned xe, int unsigned ye, int unsigned c,
                                         int unsigned sx, int unsigned sy,
                                         int unsigned w, int unsigned h);
        cmd_item_t it;
        it.op     = op;
        it.x      = x;
        it.y      = y;
        it.x_end  = xe;
        it.y_end  = ye;
        it.color  = c;
        it.src_x  = sx;
        it.src_y  = sy;
        it.width  = w;
        it.height = h;
        return it;
    endfunction

    // Random command for the current visible area xr by yr. Most commands are legal
    // and land in a small window near the origin, so that reads and copies see what
    // earlier draws left there. Fields a command does not use keep random content.
    function automatic cmd_item_t random_cmd(int unsigned xr, int unsigned yr);
        cmd_item_t   it;
        int unsigned pick;
        int unsigned wx;
        int unsigned wy;
        int unsigned px;
        int unsigned py;
        int unsigned len;
        int unsigned w;
        int unsigned h;
        it.op     = $urandom;
        it.x      = $urandom;
        it.y      = $urandom;
        it.x_end  = $urandom;
        it.y_end  = $urandom;
        it.color  = $urandom;
        it.src_x  = $urandom;
        it.src_y  = $urandom;
        it.width  = $urandom;
        it.height = $urandom;
        // With a zero resolution every command is rejected anyway.
        if (xr == 0 || yr == 0)
            return it;
        wx = (xr <= 24 || $urandom_range(0, 3) == 0) ? xr : 24;
        wy = (yr <= 12 || $urandom_range(0, 3) == 0) ? yr : 12;
        px = $urandom_range(0, wx - 1);
        py = $urandom_range(0, wy - 1);
        if ($urandom_range(0, 9) == 0)
            px = xr - 1;
        if ($urandom_range(0, 9) == 0)
            py = yr - 1;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.op = (pick < 22) ? OP_DRAW : OP_READ;
            it.x  = px;
            it.y  = py;
        end else if (pick < 76) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
            it.x = px;
            it.y = py;
            if (pick < 64) begin
                it.op    = OP_HLINE;
                it.x_end = (px + len > xr - 1) ? xr - 1 : px + len;
            end else begin
                it.op    = OP_VLINE;
                it.y_end = (py + len > yr - 1) ? yr - 1 : py + len;
            end
        end else if (pick < 92) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            if (w > xr)
                w = xr;
            if (h > yr)
                h = yr;
            it.op     = OP_COPY;
            it.width  = w;
            it.height = h;
            it.x      = $urandom_range(0, (xr - w < wx - 1) ? xr - w : wx - 1);
            it.y      = $urandom_range(0, (yr - h < wy - 1) ? yr - h : wy - 1);
            it.src_x  = $urandom_range(0, (xr - w < wx - 1) ? xr - w : wx - 1);
            it.src_y  = $urandom_range(0, (yr - h < wy - 1) ? yr - h : wy - 1);
        end else begin
            case ($urandom_range(0, 4))
                0: it.op = $urandom_range(OP_UNDEF_LO, OP_UNDEF_HI);
                1: ;
                2:
                begin
                    // Line with its ends swapped.
                    it.op    = $urandom_range(0, 1) ? OP_HLINE : OP_VLINE;
                    it.x     = px;
                    it.y     = py;
                    it.x_end = px - 1;
                    it.y_end = py - 1;
                end
                3:
                begin
                    // Copy reaching one pixel past the right or bottom edge.
                    it.op     = OP_COPY;
                    it.width  = $urandom_range(1, 4);
                    it.height = $urandom_range(1, 4);
                    it.x      = xr - it.width + 1;
                    it.y      = $urandom_range(0, wy - 1);
                    it.src_x  = $urandom_range(0, wx - 1);
                    it.src_y  = yr - it.height + $urandom_range(0, 1);
                end
                default:
                begin
                    // Pixel access just outside the visible area.
                    it.op = $urandom_range(0, 1) ? OP_DRAW : OP_READ;
                    it.x  = $urandom_range(0, 1) ? xr : px;
                    it.y  = (it.x == px) ? yr : py;
                end
            endcase
        end
        return it;
    endfunction

    // Offers one command at the next falling edge and holds it until the transfer.
    // Valid stays high afterwards; the next call either replaces the payload or an
    // idle stretch lowers valid first.
    task automatic send_cmd(cmd_item_t it);
        @(negedge clk);
        cmd_ch.valid  <= 1'b1;
        cmd_ch.op     <= it.op;
        cmd_ch.x      <= it.x;
        cmd_ch.y      <= it.y;
        cmd_ch.x_end  <= it.x_end;
        cmd_ch.y_end  <= it.y_end;
        cmd_ch.color  <= it.color;
        cmd_ch.src_x  <= it.src_x;
        cmd_ch.src_y  <= it.src_y;
        cmd_ch.width  <= it.width;
        cmd_ch.height <= it.height;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.note_command(it);
    endtask

    task automatic push_cmd(cmd_item_t it);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        send_cmd(it);
    endtask

    // Stops offering commands and waits until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers are only rewritten once the block has nothing outstanding.
    task automatic apply_setting(int unsigned pitch, int unsigned xres, int unsigned yres,
                                 int unsigned xorm);
        drain_results();
        write_reg(CFG_LINE_PITCH, pitch);
        write_reg(CFG_X_RES, xres);
        write_reg(CFG_Y_RES, yres);
        write_reg(CFG_XOR_MODE, xorm);
        settings_used++;
    endtask

    task automatic run_phase(int unsigned pitch, int unsigned xres, int unsigned yres,
                             int unsigned xorm, int unsigned count, bit steady);
        apply_setting(pitch, xres, yres, xorm);
        no_idle = steady;
        repeat (count)
            push_cmd(random_cmd(sb.eff_xres(), sb.eff_yres()));
        no_idle = 1'b0;
    endtask

    // Result side: accepts results with random gaps and checks each one. Twice in the
    // run it holds ready low for a long stretch while the sender keeps going, so the
    // output register fills, the engine stalls and cmd.ready drops.
    initial
    begin : res_sink
        int unsigned idle_left;
        int unsigned hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                res_ch.ready <= 1'b0;
                idle_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                sb.check_result(res_ch.pixel, res_ch.fault);
                results_seen++;
                idle_left = idle_len();
                if (results_seen == 150 || results_seen == 1100)
                    hold_left = 400;
            end
        end
    end

    // Safety net. The slowest legal run is the clearing sweep plus around 2000 commands,
    // each with its work, sender gap and receiver stall; the limit is several times that.
    initial
    begin : watchdog
        #(64'd10_000_000);
        $display("CHECKS FAILED");
        $display("Timed out with %0d results outstanding.", sb.pending());
        $finish;
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        no_idle       = 1'b0;
        settings_used = 0;
        results_seen  = 0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.op     = '0;
        cmd_ch.x      = '0;
        cmd_ch.y      = '0;
        cmd_ch.x_end  = '0;
        cmd_ch.y_end  = '0;
        cmd_ch.color  = '0;
        cmd_ch.src_x  = '0;
        cmd_ch.src_y  = '0;
        cmd_ch.width  = '0;
        cmd_ch.height = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block takes register writes during its clearing sweep. A write to an
        // index that decodes to nothing must leave every register alone.
        write_reg(CFG_UNUSED, 11'h7ff);

        // Directed part. Oversized register values are clipped to 512 / 1024 / 512,
        // which makes the whole field range of x and y visible.
        apply_setting(1023, 2047, 1023, 0);
        push_cmd(cmd_of(OP_DRAW, 0, 0, 0, 0, 15, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_DRAW, 1023, 511, 0, 0, 10, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 1023, 511, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_HLINE, 0, 1, 1023, 0, 5, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_VLINE, 2, 0, 0, 511, 9, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 2, 1, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_COPY, 0, 2, 0, 0, 0, 0, 1, 1024, 1));
        // Copy onto itself shifted one pixel right: the leftmost pixel smears along.
        push_cmd(cmd_of(OP_COPY, 1, 0, 0, 0, 0, 0, 0, 8, 1));
        push_cmd(cmd_of(OP_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_COPY, 1023, 0, 0, 0, 0, 2, 0, 1, 512));
        // Reversed line ends, undefined opcodes, empty and oversized copies.
        push_cmd(cmd_of(OP_HLINE, 5, 3, 4, 0, 7, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_VLINE, 6, 7, 0, 6, 7, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_UNDEF_LO, 0, 0, 0, 0, 1, 0, 0, 1, 1));
        push_cmd(cmd_of(OP_UNDEF_HI, 1023, 511, 1023, 511, 15, 1023, 511, 2047, 1023));
        push_cmd(cmd_of(OP_COPY, 0, 0, 0, 0, 0, 8, 8, 0, 4));
        push_cmd(cmd_of(OP_COPY, 0, 0, 0, 0, 0, 8, 8, 4, 0));
        push_cmd(cmd_of(OP_COPY, 0, 0, 0, 0, 0, 0, 0, 2047, 1023));

        // XOR drawing with a zero pitch, where every line maps onto the first row.
        apply_setting(0, 640, 480, 1);
        push_cmd(cmd_of(OP_DRAW, 3, 3, 0, 0, 6, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_DRAW, 640, 0, 0, 0, 3, 0, 0, 0, 0));
        push_cmd(cmd_of(OP_READ, 0, 480, 0, 0, 0, 0, 0, 0, 0));

        // A zero resolution rejects everything.
        apply_setting(320, 0, 480, 0);
        push_cmd(cmd_of(OP_DRAW, 0, 0, 0, 0, 4, 0, 0, 0, 0));

        // Random part over a range of register settings.
        run_phase(320, 640, 480, 0, 300, 1'b0);
        run_phase(4, 8, 8, 1, 300, 1'b0);
        run_phase(1023, 2047, 1023, 1, 250, 1'b0);
        run_phase(0, 16, 16, 0, 200, 1'b0);
        run_phase(1, 1, 1, 0, 80, 1'b0);
        run_phase(7, 0, 5, 1, 40, 1'b0);
        run_phase(512, 1024, 512, 0, 250, 1'b1);
        repeat (4)
            run_phase($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 40),
                      $urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(0, 1),
                      150, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);

        $display("Summary: %0d commands (draw %0d, read %0d, hline %0d, vline %0d, copy %0d,",
                 sb.checked, sb.per_op[OP_DRAW], sb.per_op[OP_READ], sb.per_op[OP_HLINE],
                 sb.per_op[OP_VLINE], sb.per_op[OP_COPY]);
        $display("Summary: undefined %0d) over %0d register settings, %0d rejected, %0d mismatches.",
                 sb.per_op[5] + sb.per_op[6] + sb.per_op[7], settings_used, sb.rejected,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
